FILE: rtl/core/fsq_pkg.sv
`default_nettype none

package fsq_pkg;

  localparam int SLOTS = 32;
  localparam int ID_W  = $clog2(SLOTS);

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_ZOMBIE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_READY = 2'd0,
    CMD_BLOCK = 2'd1,
    CMD_EXIT  = 2'd2,
    CMD_SCHED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_ACK      = 2'd0,
    OUT_SCHED    = 2'd1,
    OUT_SHUTDOWN = 2'd2,
    OUT_STUCK    = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WREAD,
    S_WTGT,
    S_WEVAL,
    S_POP,
    S_POPD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/fsq_ram.sv
`default_nettype none

module fsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/fifo_scheduler_with_wait_queue_core.sv
`default_nettype none

// FIFO ready-queue scheduler with a wait queue. Slot status, wait targets and
// the next-slot links of the ready and blocked queues sit in single-port-read
// RAMs; head/tail registers and per-slot membership and liveness flags are
// flops. One item is taken at a time. A schedule item walks the wait queue,
// doing for each blocked-queue entry a link/target read, a status read of the
// target and an update, then reads the ready-queue head and pops it unless
// the ready queue is empty. A new item is accepted while the previous result
// waits at the output register.
module fifo_scheduler_with_wait_queue_core
  import fsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  id_t        proc_id,
  input  id_t        waited_id,
  input  logic       exit_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] outcome,
  output id_t        chosen_id
);

  state_t state, state_next;

  logic             accept, out_free, zombie, last;
  id_t              rhead, rtail, bhead, btail;
  logic             rvalid, bvalid;
  logic [SLOTS-1:0] in_ready, in_blocked, live, written;
  id_t              cur, nxt, prev, tgt;
  logic             has_prev;
  outcome_t         res_outcome;
  id_t              res_chosen;

  logic       st_we, tg_we, rl_we, bl_we;
  id_t        st_waddr, tg_waddr, rl_waddr, bl_waddr;
  logic [2:0] st_wdata, st_rdata;
  id_t        tg_wdata, rl_wdata, bl_wdata;
  id_t        st_raddr, tg_raddr, rl_raddr, bl_raddr;
  id_t        tg_rdata, rl_rdata, bl_rdata;

  fsq_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_status (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  fsq_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_target (
    .clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
    .raddr(tg_raddr), .rdata(tg_rdata)
  );
  fsq_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_rlink (
    .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
    .raddr(rl_raddr), .rdata(rl_rdata)
  );
  fsq_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_blink (
    .clk(clk), .we(bl_we), .waddr(bl_waddr), .wdata(bl_wdata),
    .raddr(bl_raddr), .rdata(bl_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign zombie   = written[tgt] && (st_rdata == ST_ZOMBIE);
  assign last     = (cur == btail);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(cmd) == CMD_SCHED) begin
            state_next = bvalid ? S_WREAD : S_POP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WREAD: state_next = S_WTGT;
      S_WTGT:  state_next = S_WEVAL;
      S_WEVAL: state_next = last ? S_POP : S_WREAD;
      S_POP:   state_next = rvalid ? S_POPD : S_DONE;
      S_POPD:  state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    st_we = 1'b0; st_waddr = '0; st_wdata = ST_FREE; st_raddr = '0;
    tg_we = 1'b0; tg_waddr = '0; tg_wdata = '0;      tg_raddr = '0;
    rl_we = 1'b0; rl_waddr = '0; rl_wdata = '0;      rl_raddr = '0;
    bl_we = 1'b0; bl_waddr = '0; bl_wdata = '0;      bl_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_READY: begin
              if (!in_ready[proc_id]) begin
                st_we = 1'b1; st_waddr = proc_id; st_wdata = ST_READY;
                rl_we = rvalid; rl_waddr = rtail; rl_wdata = proc_id;
              end
            end
            CMD_BLOCK: begin
              tg_we = 1'b1; tg_waddr = proc_id; tg_wdata = waited_id;
              if (!in_blocked[proc_id]) begin
                st_we = 1'b1; st_waddr = proc_id; st_wdata = ST_BLOCKED;
                bl_we = bvalid; bl_waddr = btail; bl_wdata = proc_id;
              end
            end
            CMD_EXIT: begin
              st_we = 1'b1; st_waddr = proc_id;
              st_wdata = exit_kind ? ST_ZOMBIE : ST_FREE;
            end
            default: ;
          endcase
        end
      end
      S_WREAD: begin
        bl_raddr = cur;
        tg_raddr = cur;
      end
      S_WTGT: st_raddr = tg_rdata;
      S_WEVAL: begin
        if (zombie) begin
          if (!in_ready[cur]) begin
            st_we = 1'b1; st_waddr = cur; st_wdata = ST_READY;
            rl_we = rvalid; rl_waddr = rtail; rl_wdata = cur;
          end
          bl_we = has_prev; bl_waddr = prev; bl_wdata = nxt;
        end
      end
      S_POP:  rl_raddr = rhead;
      S_POPD: begin
        st_we = 1'b1; st_waddr = rhead; st_wdata = ST_RUNNING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rvalid     <= 1'b0;
      bvalid     <= 1'b0;
      in_ready   <= '0;
      in_blocked <= '0;
      live       <= '0;
      written    <= '0;
      has_prev   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        outcome   <= res_outcome;
        chosen_id <= res_chosen;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_outcome <= OUT_ACK;
            res_chosen  <= '0;
            has_prev    <= 1'b0;
            cur         <= bhead;
            unique case (cmd_t'(cmd))
              CMD_READY: begin
                if (!in_ready[proc_id]) begin
                  in_ready[proc_id] <= 1'b1;
                  written[proc_id]  <= 1'b1;
                  live[proc_id]     <= 1'b1;
                  if (!rvalid) begin
                    rhead  <= proc_id;
                    rvalid <= 1'b1;
                  end
                  rtail <= proc_id;
                end
              end
              CMD_BLOCK: begin
                if (!in_blocked[proc_id]) begin
                  in_blocked[proc_id] <= 1'b1;
                  written[proc_id]    <= 1'b1;
                  live[proc_id]       <= 1'b1;
                  if (!bvalid) begin
                    bhead  <= proc_id;
                    bvalid <= 1'b1;
                  end
                  btail <= proc_id;
                end
              end
              CMD_EXIT: begin
                written[proc_id] <= 1'b1;
                live[proc_id]    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WTGT: begin
          nxt <= bl_rdata;
          tgt <= tg_rdata;
        end
        S_WEVAL: begin
          if (zombie) begin
            if (!in_ready[cur]) begin
              in_ready[cur] <= 1'b1;
              written[cur]  <= 1'b1;
              live[cur]     <= 1'b1;
              if (!rvalid) begin
                rhead  <= cur;
                rvalid <= 1'b1;
              end
              rtail <= cur;
            end
            in_blocked[cur] <= 1'b0;
            if (!has_prev) begin
              if (last) begin
                bvalid <= 1'b0;
              end else begin
                bhead <= nxt;
              end
            end else if (last) begin
              btail <= prev;
            end
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
          end
          cur <= nxt;
        end
        S_POP: begin
          if (!rvalid) begin
            res_outcome <= (live == '0) ? OUT_SHUTDOWN : OUT_STUCK;
          end
        end
        S_POPD: begin
          res_outcome     <= OUT_SCHED;
          res_chosen      <= rhead;
          in_ready[rhead] <= 1'b0;
          written[rhead]  <= 1'b1;
          live[rhead]     <= 1'b1;
          if (rhead == rtail) begin
            rvalid <= 1'b0;
          end else begin
            rhead <= rl_rdata;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/fifo_scheduler_with_wait_queue_core_tb.sv
`timescale 1ns / 100ps

module fifo_scheduler_with_wait_queue_core_tb;
  import fsq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_READY;
  id_t proc_id = '0;
  id_t waited_id = '0;
  logic exit_kind = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] outcome;
  id_t chosen_id;

  always #5 clk = ~clk;

  fifo_scheduler_with_wait_queue_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .proc_id(proc_id), .waited_id(waited_id), .exit_kind(exit_kind),
    .out_valid(out_valid), .out_stall(out_stall),
    .outcome(outcome), .chosen_id(chosen_id)
  );

  typedef struct packed {
    outcome_t oc;
    id_t id;
  } sched_result_t;

  typedef struct {
    cmd_t c;
    id_t pid;
    id_t wid;
    logic kind;
    bit typed;
    outcome_t oc;
    id_t id;
  } row_t;

  status_t slot_st[SLOTS];
  id_t wait_on[SLOTS];
  id_t rdy_next[SLOTS];
  id_t blk_next[SLOTS];
  id_t rdy_head, rdy_tail, blk_head, blk_tail;
  bit rdy_any, blk_any;

  sched_result_t expected_q[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic bit in_list(bit rdy, id_t id);
    id_t p;
    id_t tl;
    if (rdy ? !rdy_any : !blk_any) return 1'b0;
    p = rdy ? rdy_head : blk_head;
    tl = rdy ? rdy_tail : blk_tail;
    for (int k = 0; k < SLOTS; k++) begin
      if (p == id) return 1'b1;
      if (p == tl) return 1'b0;
      p = rdy ? rdy_next[p] : blk_next[p];
    end
    return 1'b0;
  endfunction

  function automatic void add_ready(id_t id);
    if (in_list(1'b1, id)) return;
    slot_st[id] = ST_READY;
    if (!rdy_any) begin
      rdy_head = id;
      rdy_any = 1'b1;
    end else begin
      rdy_next[rdy_tail] = id;
    end
    rdy_tail = id;
  endfunction

  function automatic void wake_blocked();
    id_t cur, nxt, prev;
    bit has_prev, last;
    has_prev = 1'b0;
    prev = '0;
    if (!blk_any) return;
    cur = blk_head;
    for (int k = 0; k < SLOTS; k++) begin
      last = (cur == blk_tail);
      nxt = blk_next[cur];
      if (slot_st[wait_on[cur]] == ST_ZOMBIE) begin
        add_ready(cur);
        if (!has_prev) begin
          if (last) blk_any = 1'b0;
          else blk_head = nxt;
        end else begin
          blk_next[prev] = nxt;
          if (last) blk_tail = prev;
        end
      end else begin
        prev = cur;
        has_prev = 1'b1;
      end
      if (last) break;
      cur = nxt;
    end
  endfunction

  function automatic sched_result_t apply_item(cmd_t c, id_t pid, id_t wid, logic kind);
    sched_result_t r;
    bit all_done;
    r = '{OUT_ACK, '0};
    case (c)
      CMD_READY: add_ready(pid);
      CMD_BLOCK: begin
        wait_on[pid] = wid;
        if (!in_list(1'b0, pid)) begin
          slot_st[pid] = ST_BLOCKED;
          if (!blk_any) begin
            blk_head = pid;
            blk_any = 1'b1;
          end else begin
            blk_next[blk_tail] = pid;
          end
          blk_tail = pid;
        end
      end
      CMD_EXIT: slot_st[pid] = kind ? ST_ZOMBIE : ST_FREE;
      default: begin
        wake_blocked();
        if (rdy_any) begin
          r = '{OUT_SCHED, rdy_head};
          if (rdy_head == rdy_tail) rdy_any = 1'b0;
          else rdy_head = rdy_next[rdy_head];
          slot_st[r.id] = ST_RUNNING;
        end else begin
          all_done = 1'b1;
          for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] != ST_FREE && slot_st[i] != ST_ZOMBIE) all_done = 1'b0;
          r.oc = all_done ? OUT_SHUTDOWN : OUT_STUCK;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(cmd_t c, id_t pid, id_t wid, logic kind, bit typed,
                           sched_result_t want);
    sched_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd <= c;
    proc_id <= pid;
    waited_id <= wid;
    exit_kind <= kind;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_item(c, pid, wid, kind);
    expected_q.push_back(typed ? want : r);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("outcome: unexpected result %0d, chosen_id %0d", outcome, chosen_id);
        errors++;
      end else begin
        if (outcome !== expected_q[0].oc) begin
          $error("outcome: expected %0d, actual %0d", expected_q[0].oc, outcome);
          errors++;
        end
        if (chosen_id !== expected_q[0].id) begin
          $error("chosen_id: expected %0d, actual %0d", expected_q[0].id, chosen_id);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    cmd_t c;
    id_t pid, wid;
    int n;

    for (int i = 0; i < SLOTS; i++) slot_st[i] = ST_FREE;
    rdy_any = 1'b0;
    blk_any = 1'b0;
    rdy_head = '0; rdy_tail = '0; blk_head = '0; blk_tail = '0;

    rows = '{
      '{CMD_SCHED, 0, 0, 0, 1, OUT_SHUTDOWN, 0},
      '{CMD_READY, 0, 0, 0, 1, OUT_ACK, 0},
      '{CMD_READY, 31, 31, 1, 1, OUT_ACK, 0},
      '{CMD_READY, 0, 0, 0, 1, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 1, OUT_SCHED, 0},
      '{CMD_SCHED, 31, 31, 1, 1, OUT_SCHED, 31},
      '{CMD_SCHED, 0, 0, 0, 1, OUT_STUCK, 0},
      '{CMD_EXIT, 0, 0, 0, 1, OUT_ACK, 0},
      '{CMD_EXIT, 31, 0, 1, 1, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 1, OUT_SHUTDOWN, 0},
      '{CMD_BLOCK, 5, 31, 0, 0, OUT_ACK, 0},
      '{CMD_BLOCK, 6, 7, 0, 0, OUT_ACK, 0},
      '{CMD_BLOCK, 5, 31, 0, 0, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 1, OUT_SCHED, 5},
      '{CMD_SCHED, 0, 0, 0, 1, OUT_STUCK, 0},
      '{CMD_EXIT, 7, 0, 1, 0, OUT_ACK, 0},
      '{CMD_READY, 6, 0, 0, 0, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 0, OUT_ACK, 0},
      '{CMD_BLOCK, 9, 10, 0, 0, OUT_ACK, 0},
      '{CMD_BLOCK, 10, 11, 0, 0, OUT_ACK, 0},
      '{CMD_EXIT, 11, 0, 1, 0, OUT_ACK, 0},
      '{CMD_EXIT, 10, 0, 1, 0, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 0, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 0, OUT_ACK, 0},
      '{CMD_SCHED, 0, 0, 0, 0, OUT_ACK, 0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].c, rows[i].pid, rows[i].wid, rows[i].kind, rows[i].typed,
                '{rows[i].oc, rows[i].id});

    for (int i = 0; i < 1530; i++) begin
      if (i == 1350) quiet = 1'b1;
      n = $urandom_range(0, 9);
      c = (n < 3) ? CMD_READY : (n < 5) ? CMD_BLOCK : (n < 7) ? CMD_EXIT : CMD_SCHED;
      if ($urandom_range(0, 4) == 0) begin
        pid = id_t'($urandom_range(0, SLOTS - 1));
        wid = id_t'($urandom_range(0, SLOTS - 1));
      end else begin
        pid = id_t'($urandom_range(0, 7));
        wid = id_t'($urandom_range(0, 7));
      end
      send_item(c, pid, wid, 1'($urandom_range(0, 1)), 1'b0, '{OUT_ACK, 0});
    end
    in_valid <= 1'b0;

    n = 0;
    while (expected_q.size() != 0 && n < 10000) begin
      @(posedge clk);
      n++;
    end
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_q.size() != 0) $error("outcome: %0d results never arrived", expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fsq_pkg.sv
rtl/core/fsq_ram.sv
rtl/core/fifo_scheduler_with_wait_queue_core.sv
bench/fifo_scheduler_with_wait_queue_core_tb.sv
